FILE: sv/mscell_pkg.sv
// mscell_pkg: shared widths, codes, cell record types and case tables
// for the marching squares cell unit; used by every module of the block
// depends on nothing
package mscell_pkg;

    localparam int SAMPLE_W           = 8;
    localparam int CELL_W             = 6;
    localparam int OUT_W              = 22;
    localparam int EDGE_W             = SAMPLE_W + 1;
    localparam int NUM_EDGES          = 4;
    localparam int MAX_VERTS          = 9;
    localparam int CNT_W              = 4;
    localparam int SHAPE_W            = 3;
    localparam int ROT_W              = 2;
    localparam int CODE_W             = 3;
    localparam int NUM_SHAPES         = 6;
    localparam int QUEUE_DEPTH        = 2;
    localparam int DEF_CELLS_PER_SIDE = 64;
    localparam int DEF_FRAC_BITS      = 15;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = REG_IDX_W'(0);

    // edge lanes
    localparam int EDGE_TOP    = 0;
    localparam int EDGE_RIGHT  = 1;
    localparam int EDGE_BOTTOM = 2;
    localparam int EDGE_LEFT   = 3;

    // local vertex codes, walking the cell border
    localparam logic [CODE_W-1:0] VC_TOP_LEFT     = 3'd0;
    localparam logic [CODE_W-1:0] VC_TOP_EDGE     = 3'd1;
    localparam logic [CODE_W-1:0] VC_TOP_RIGHT    = 3'd2;
    localparam logic [CODE_W-1:0] VC_RIGHT_EDGE   = 3'd3;
    localparam logic [CODE_W-1:0] VC_BOTTOM_RIGHT = 3'd4;
    localparam logic [CODE_W-1:0] VC_BOTTOM_EDGE  = 3'd5;
    localparam logic [CODE_W-1:0] VC_BOTTOM_LEFT  = 3'd6;
    localparam logic [CODE_W-1:0] VC_LEFT_EDGE   = 3'd7;

    localparam logic [SHAPE_W-1:0] SHAPE_OF_CASE [16] = '{
        3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd5, 3'd4,
        3'd1, 3'd5, 3'd2, 3'd4, 3'd2, 3'd4, 3'd4, 3'd3
    };
    localparam logic [ROT_W-1:0] ROT_OF_CASE [16] = '{
        2'd0, 2'd0, 2'd1, 2'd0, 2'd3, 2'd3, 2'd1, 2'd0,
        2'd2, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0
    };
    localparam logic [CNT_W-1:0] SHAPE_LEN [NUM_SHAPES] = '{
        4'd0, 4'd3, 4'd6, 4'd6, 4'd9, 4'd6
    };
    localparam logic [CODE_W-1:0] SHAPE_CODES [NUM_SHAPES][MAX_VERTS] = '{
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd7, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd7, 3'd2, 3'd2, 3'd7, 3'd3, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd6, 3'd4, 3'd4, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd6, 3'd5, 3'd5, 3'd3, 3'd0, 3'd0, 3'd3, 3'd2},
        '{3'd0, 3'd7, 3'd1, 3'd5, 3'd4, 3'd3, 3'd0, 3'd0, 3'd0}
    };

    typedef struct packed {
        logic [CELL_W-1:0]  cx;
        logic [CELL_W-1:0]  cy;
        logic               odd;
        logic [SHAPE_W-1:0] shape;
        logic [ROT_W-1:0]   rot;
        logic [CNT_W-1:0]   count;
    } job_t;

    typedef struct packed {
        job_t                               job;
        logic [NUM_EDGES-1:0][EDGE_W-1:0]   num;
        logic [NUM_EDGES-1:0][EDGE_W-1:0]   den;
    } cell_t;

    function automatic logic [SHAPE_W-1:0] shape_len_idx_ok(input logic [SHAPE_W-1:0] shape);
        return (shape < SHAPE_W'(NUM_SHAPES)) ? shape : '0;
    endfunction

    function automatic logic [CNT_W-1:0] shape_len(input logic [SHAPE_W-1:0] shape);
        return SHAPE_LEN[shape_len_idx_ok(shape)];
    endfunction

    function automatic logic [CODE_W-1:0] shape_code(input logic [SHAPE_W-1:0] shape,
                                                     input logic [CNT_W-1:0]   k);
        logic [CODE_W-1:0] code;
        code = '0;
        if (k < CNT_W'(MAX_VERTS))
        begin
            code = SHAPE_CODES[shape_len_idx_ok(shape)][k];
        end
        return code;
    endfunction

endpackage

FILE: sv/mscell_front.sv
// mscell_front: classifies one cell: corner case, shape, rotation, vertex
// count, saturated cell position and the edge numerators and denominators
// depends on mscell_pkg
module mscell_front #(
    parameter int CELLS_PER_SIDE = mscell_pkg::DEF_CELLS_PER_SIDE
) (
    input  logic [mscell_pkg::SAMPLE_W-1:0] corner_top_left,
    input  logic [mscell_pkg::SAMPLE_W-1:0] corner_top_right,
    input  logic [mscell_pkg::SAMPLE_W-1:0] corner_bottom_left,
    input  logic [mscell_pkg::SAMPLE_W-1:0] corner_bottom_right,
    input  logic [mscell_pkg::CELL_W-1:0]   cell_x,
    input  logic [mscell_pkg::CELL_W-1:0]   cell_y,
    input  logic [mscell_pkg::SAMPLE_W-1:0] threshold,
    output mscell_pkg::cell_t               item,
    output logic                            has_verts
);

    localparam int SIDE_W = $clog2(CELLS_PER_SIDE + 1);
    localparam int CMP_W  = (SIDE_W > mscell_pkg::CELL_W) ? SIDE_W : mscell_pkg::CELL_W;
    localparam int EW     = mscell_pkg::EDGE_W;

    logic [3:0]                       cell_case;
    logic [mscell_pkg::CELL_W-1:0]    cx;
    logic [mscell_pkg::CELL_W-1:0]    cy;
    logic [EW-1:0]                    tl;
    logic [EW-1:0]                    tr;
    logic [EW-1:0]                    bl;
    logic [EW-1:0]                    br;
    logic [EW-1:0]                    lim;

    always_comb
    begin
        tl  = EW'(corner_top_left);
        tr  = EW'(corner_top_right);
        bl  = EW'(corner_bottom_left);
        br  = EW'(corner_bottom_right);
        lim = EW'(threshold);

        cell_case[0] = corner_top_left     > threshold;
        cell_case[1] = corner_top_right    > threshold;
        cell_case[2] = corner_bottom_left  > threshold;
        cell_case[3] = corner_bottom_right > threshold;

        cx = cell_x;
        if (CMP_W'(cell_x) >= CMP_W'(CELLS_PER_SIDE))
        begin
            cx = mscell_pkg::CELL_W'(CELLS_PER_SIDE - 1);
        end
        cy = cell_y;
        if (CMP_W'(cell_y) >= CMP_W'(CELLS_PER_SIDE))
        begin
            cy = mscell_pkg::CELL_W'(CELLS_PER_SIDE - 1);
        end

        item.job.cx    = cx;
        item.job.cy    = cy;
        item.job.odd   = cx[0] ^ cy[0];
        item.job.shape = mscell_pkg::SHAPE_OF_CASE[cell_case];
        item.job.rot   = mscell_pkg::ROT_OF_CASE[cell_case];
        item.job.count = mscell_pkg::shape_len(mscell_pkg::SHAPE_OF_CASE[cell_case]);

        item.num[mscell_pkg::EDGE_TOP]    = tl - lim;
        item.den[mscell_pkg::EDGE_TOP]    = tl - tr;
        item.num[mscell_pkg::EDGE_RIGHT]  = br - lim;
        item.den[mscell_pkg::EDGE_RIGHT]  = br - tr;
        item.num[mscell_pkg::EDGE_BOTTOM] = bl - lim;
        item.den[mscell_pkg::EDGE_BOTTOM] = bl - br;
        item.num[mscell_pkg::EDGE_LEFT]   = bl - lim;
        item.den[mscell_pkg::EDGE_LEFT]   = bl - tl;

        has_verts = (cell_case != 4'd0);
    end

endmodule

FILE: sv/mscell_queue.sv
// mscell_queue: short register queue of classified cells between the
// front and the divide stage
// depends on mscell_pkg
module mscell_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mscell_pkg::cell_t push_item,
    input  logic              pop,
    output mscell_pkg::cell_t head_item,
    output logic              full,
    output logic              empty
);

    localparam int DEPTH = mscell_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mscell_pkg::cell_t entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item = entry_reg[rd_ptr_reg];
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

endmodule

FILE: sv/mscell_div_lane.sv
// mscell_div_lane: one edge fraction (a-limit)/(a-b) by restoring division,
// two quotient bits a cycle while step is high; zero and clamp decided at load
// depends on mscell_pkg
module mscell_div_lane #(
    parameter int FRAC_BITS = mscell_pkg::DEF_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic                          step,
    input  logic [mscell_pkg::EDGE_W-1:0] num,
    input  logic [mscell_pkg::EDGE_W-1:0] den,
    output logic [FRAC_BITS:0]            frac
);

    localparam int SW    = mscell_pkg::SAMPLE_W;
    localparam int EW    = mscell_pkg::EDGE_W;
    localparam int STEPS = (FRAC_BITS + 1) / 2;
    localparam int QW    = 2 * STEPS;
    localparam int SHIFT = QW - FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic          zero_reg;
    logic          zero_next;
    logic          one_reg;
    logic          one_next;
    logic [SW-1:0] rem_reg;
    logic [SW-1:0] rem_next;
    logic [SW-1:0] dvs_reg;
    logic [SW-1:0] dvs_next;
    logic [QW-1:0] quo_reg;
    logic [QW-1:0] quo_next;
    logic [EW-1:0] mag_num;
    logic [EW-1:0] mag_den;
    logic [EW-1:0] r1;
    logic [EW-1:0] r1s;
    logic [EW-1:0] r2;
    logic [EW-1:0] r2s;
    logic          b1;
    logic          b2;

    always_comb
    begin
        mag_num = num[EW-1] ? (EW'(0) - num) : num;
        mag_den = den[EW-1] ? (EW'(0) - den) : den;

        r1  = {rem_reg, 1'b0};
        b1  = r1 >= EW'(dvs_reg);
        r1s = b1 ? (r1 - EW'(dvs_reg)) : r1;
        r2  = {r1s[SW-1:0], 1'b0};
        b2  = r2 >= EW'(dvs_reg);
        r2s = b2 ? (r2 - EW'(dvs_reg)) : r2;

        zero_next = zero_reg;
        one_next  = one_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (load)
        begin
            // opposite signs or an empty edge give a fraction of zero
            zero_next = (den == '0) || (num == '0) || (num[EW-1] != den[EW-1]);
            one_next  = (mag_num >= mag_den);
            rem_next  = mag_num[SW-1:0];
            dvs_next  = mag_den[SW-1:0];
            quo_next  = '0;
        end
        else if (step)
        begin
            rem_next = r2s[SW-1:0];
            quo_next = {quo_reg[QW-3:0], b1, b2};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg <= 1'b1;
            one_reg  <= 1'b0;
        end
        else
        begin
            zero_reg <= zero_next;
            one_reg  <= one_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    always_comb
    begin
        if (zero_reg)
        begin
            frac = '0;
        end
        else if (one_reg)
        begin
            frac = ONE;
        end
        else
        begin
            frac = (FRAC_BITS + 1)'(quo_reg >> SHIFT);
        end
    end

endmodule

FILE: sv/mscell_divide.sv
// mscell_divide: takes cells from the queue and computes the edge fractions
// in parallel lanes, one per edge, then hands cell and fractions to the emitter
// depends on mscell_pkg and mscell_div_lane
module mscell_divide #(
    parameter int FRAC_BITS = mscell_pkg::DEF_FRAC_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  queue_empty,
    input  mscell_pkg::cell_t     head_item,
    output logic                  pop,
    output logic                  job_valid,
    output mscell_pkg::job_t      job,
    output logic [mscell_pkg::NUM_EDGES-1:0][FRAC_BITS:0] frac,
    input  logic                  emit_ready
);

    localparam int STEPS = (FRAC_BITS + 1) / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    mscell_pkg::job_t job_reg;
    logic             done;
    logic             load;
    logic             step;

    always_comb
    begin
        done      = busy_reg && (cnt_reg == '0);
        load      = !queue_empty && (!busy_reg || (done && emit_ready));
        step      = busy_reg && (cnt_reg != '0);
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS);
        end
        else if (done && emit_ready)
        begin
            busy_next = 1'b0;
        end
        else if (step)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= head_item.job;
        end
    end

    for (genvar e = 0; e < mscell_pkg::NUM_EDGES; e++)
    begin : g_lane
        mscell_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .load  (load),
            .step  (step),
            .num   (head_item.num[e]),
            .den   (head_item.den[e]),
            .frac  (frac[e])
        );
    end

    assign pop       = load;
    assign job_valid = done;
    assign job       = job_reg;

endmodule

FILE: sv/mscell_emit.sv
// mscell_emit: walks the shape of one cell, one vertex a cycle, rotating
// each code and building position and texture coordinates
// depends on mscell_pkg
module mscell_emit #(
    parameter int FRAC_BITS = mscell_pkg::DEF_FRAC_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    input  mscell_pkg::job_t      job,
    input  logic [mscell_pkg::NUM_EDGES-1:0][FRAC_BITS:0] frac,
    output logic                  emit_ready,
    output logic                  vertex_strobe,
    output logic [mscell_pkg::OUT_W-1:0] pos_x,
    output logic [mscell_pkg::OUT_W-1:0] pos_y,
    output logic [mscell_pkg::OUT_W-1:0] tex_u,
    output logic [mscell_pkg::OUT_W-1:0] tex_v,
    output logic                  last_vertex
);

    localparam int OW    = mscell_pkg::OUT_W;
    localparam int CW    = mscell_pkg::CELL_W;
    localparam int KW    = mscell_pkg::CNT_W;
    localparam int SUM_W = CW + FRAC_BITS + 1;
    localparam int PW    = (SUM_W > OW) ? SUM_W : OW;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic                       valid_reg;
    logic                       valid_next;
    logic [KW-1:0]              k_reg;
    logic [KW-1:0]              k_next;
    mscell_pkg::job_t           job_reg;
    logic [mscell_pkg::NUM_EDGES-1:0][FRAC_BITS:0] frac_reg;
    logic                       last;
    logic                       take;
    logic [mscell_pkg::CODE_W-1:0] code;
    logic [FRAC_BITS:0]         u;
    logic [FRAC_BITS:0]         v;
    logic [PW-1:0]              u_ext;
    logic [PW-1:0]              v_ext;
    logic [PW-1:0]              sum_x;
    logic [PW-1:0]              sum_y;

    always_comb
    begin
        last       = valid_reg && (k_reg == job_reg.count - KW'(1));
        emit_ready = !valid_reg || last;
        take       = job_valid && emit_ready;
        valid_next = valid_reg;
        k_next     = k_reg;
        if (take)
        begin
            valid_next = 1'b1;
            k_next     = '0;
        end
        else if (last)
        begin
            valid_next = 1'b0;
        end
        else if (valid_reg)
        begin
            k_next = k_reg + KW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg  <= job;
            frac_reg <= frac;
        end
    end

    always_comb
    begin
        // two code steps per quarter turn, wrapping around the border
        code = mscell_pkg::shape_code(job_reg.shape, k_reg) + {job_reg.rot, 1'b0};
        case (code)
            mscell_pkg::VC_TOP_LEFT:
            begin
                u = '0;
                v = ONE;
            end
            mscell_pkg::VC_TOP_EDGE:
            begin
                u = frac_reg[mscell_pkg::EDGE_TOP];
                v = ONE;
            end
            mscell_pkg::VC_TOP_RIGHT:
            begin
                u = ONE;
                v = ONE;
            end
            mscell_pkg::VC_RIGHT_EDGE:
            begin
                u = ONE;
                v = frac_reg[mscell_pkg::EDGE_RIGHT];
            end
            mscell_pkg::VC_BOTTOM_RIGHT:
            begin
                u = ONE;
                v = '0;
            end
            mscell_pkg::VC_BOTTOM_EDGE:
            begin
                u = frac_reg[mscell_pkg::EDGE_BOTTOM];
                v = '0;
            end
            mscell_pkg::VC_BOTTOM_LEFT:
            begin
                u = '0;
                v = '0;
            end
            default:
            begin
                u = '0;
                v = frac_reg[mscell_pkg::EDGE_LEFT];
            end
        endcase

        u_ext = PW'(u);
        v_ext = PW'(v);
        sum_x = (PW'(job_reg.cx) << FRAC_BITS) + u_ext;
        sum_y = (PW'(job_reg.cy) << FRAC_BITS) + v_ext;

        pos_x = sum_x[OW-1:0];
        pos_y = sum_y[OW-1:0];
        tex_u = job_reg.odd ? sum_x[OW-1:0] : u_ext[OW-1:0];
        tex_v = job_reg.odd ? sum_y[OW-1:0] : v_ext[OW-1:0];
    end

    assign vertex_strobe = valid_reg;
    assign last_vertex   = last;

endmodule

FILE: sv/marching_squares_cell_unit.sv
// marching_squares_cell_unit: top level of the marching squares cell mesher
// holds the threshold register and joins front, queue, divide and emit
// depends on mscell_pkg, mscell_front, mscell_queue, mscell_divide, mscell_emit
//
//  channel   signals                                   transfer when
//  cell in   start, busy, corner_*, cell_x, cell_y     start && !busy
//  config    psel, penable, pwrite, paddr, pwdata,     psel && penable && pwrite
//            prdata, pready                             (pready tied high)
//  vertex    vertex_strobe, pos_*, tex_*, last_vertex  every cycle vertex_strobe is high
//
//  a cell goes front -> queue of QUEUE_DEPTH entries -> divide (one lane per edge) -> emit.
//  the edge lanes load a cell, step through its quotient bits and hand it over;
//  emit sends one vertex a cycle, up to 9 per cell. divide takes the next cell
//  when idle or as it hands the last one to emit, so one cell is divided
//  while the one before is still being emitted; emit takes a new cell on its last vertex.
//  cells with no corner above the threshold send nothing and leave no trace.
//  busy is high while the queue is full; the receiver cannot stall vertices.
//  reset clears the threshold to 0 and empties every stage.
module marching_squares_cell_unit #(
    parameter int CELLS_PER_SIDE = mscell_pkg::DEF_CELLS_PER_SIDE,
    parameter int FRAC_BITS      = mscell_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [mscell_pkg::SAMPLE_W-1:0]   corner_top_left,
    input  logic [mscell_pkg::SAMPLE_W-1:0]   corner_top_right,
    input  logic [mscell_pkg::SAMPLE_W-1:0]   corner_bottom_left,
    input  logic [mscell_pkg::SAMPLE_W-1:0]   corner_bottom_right,
    input  logic [mscell_pkg::CELL_W-1:0]     cell_x,
    input  logic [mscell_pkg::CELL_W-1:0]     cell_y,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mscell_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mscell_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mscell_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready,
    output logic                              vertex_strobe,
    output logic [mscell_pkg::OUT_W-1:0]      pos_x,
    output logic [mscell_pkg::OUT_W-1:0]      pos_y,
    output logic [mscell_pkg::OUT_W-1:0]      tex_u,
    output logic [mscell_pkg::OUT_W-1:0]      tex_v,
    output logic                              last_vertex
);

    localparam int AW = mscell_pkg::APB_ADDR_W;
    localparam int SW = mscell_pkg::SAMPLE_W;

    logic [SW-1:0]          threshold_reg;
    logic [SW-1:0]          threshold_next;
    logic                   reg_hit;
    mscell_pkg::cell_t      front_item;
    logic                   has_verts;
    logic                   push;
    logic                   queue_full;
    logic                   queue_empty;
    logic                   pop;
    mscell_pkg::cell_t      head_item;
    logic                   job_valid;
    mscell_pkg::job_t       job;
    logic [mscell_pkg::NUM_EDGES-1:0][FRAC_BITS:0] frac;
    logic                   emit_ready;

    always_comb
    begin
        reg_hit        = (paddr[AW-1:2] == mscell_pkg::REG_THRESHOLD);
        threshold_next = threshold_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            threshold_next = pwdata[SW-1:0];
        end
        prdata = reg_hit ? mscell_pkg::APB_DATA_W'(threshold_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    assign pready = 1'b1;
    assign busy   = queue_full;
    assign push   = start && !queue_full && has_verts;

    mscell_front #(
        .CELLS_PER_SIDE (CELLS_PER_SIDE)
    ) u_front (
        .corner_top_left     (corner_top_left),
        .corner_top_right    (corner_top_right),
        .corner_bottom_left  (corner_bottom_left),
        .corner_bottom_right (corner_bottom_right),
        .cell_x              (cell_x),
        .cell_y              (cell_y),
        .threshold           (threshold_reg),
        .item                (front_item),
        .has_verts           (has_verts)
    );

    mscell_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    mscell_divide #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divide (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head_item   (head_item),
        .pop         (pop),
        .job_valid   (job_valid),
        .job         (job),
        .frac        (frac),
        .emit_ready  (emit_ready)
    );

    mscell_emit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (job_valid),
        .job           (job),
        .frac          (frac),
        .emit_ready    (emit_ready),
        .vertex_strobe (vertex_strobe),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .tex_u         (tex_u),
        .tex_v         (tex_v),
        .last_vertex   (last_vertex)
    );

endmodule
